// File: rtl/cggr_pkg.sv
package cggr_pkg;

    localparam int OLD_GLYPHS = 4096;
    localparam int GID_AW     = $clog2(OLD_GLYPHS);

    localparam logic [15:0] FIRST_COMPONENT = 16'd10;

    localparam logic [15:0] FLAG_ARGS_WORDS = 16'h0001;
    localparam logic [15:0] FLAG_SCALE      = 16'h0008;
    localparam logic [15:0] FLAG_MORE       = 16'h0020;
    localparam logic [15:0] FLAG_XY_SCALE   = 16'h0040;
    localparam logic [15:0] FLAG_TWO_BY_TWO = 16'h0080;

    localparam logic OP_MAP  = 1'b0;
    localparam logic OP_BYTE = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       pad;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic              wr_en;
        logic [GID_AW-1:0] wr_addr;
        logic [15:0]       wr_data;
        logic              rd_en;
        logic [GID_AW-1:0] rd_addr;
    } map_req_t;

endpackage

// File: rtl/composite_glyph_gid_remap.sv
// Composite glyph component id remapper.
// Slave channel: s_tuser selects the transaction kind. A map transaction
// (OP_MAP) writes one old-to-new glyph id entry; a byte transaction (OP_BYTE)
// carries one glyph record byte, with s_tlast on the final byte of a record.
// Master channel: one output byte per transaction; m_tuser flags the pad zero
// appended to an odd-length record, m_tlast marks the record's final byte.
// In a composite record each component id is looked up in a 4096-entry
// synchronous table and replaced; the id high byte is held until the low
// byte arrives, then both mapped bytes leave back to back.
// Throughput: one slave transaction per cycle while not stalled (see Stall). A byte that completes an id
// yields two output bytes, so the master side moves one byte per cycle and a
// 4-entry output queue absorbs the extra byte.
// Path: an accepted byte is registered in the read stage with its table read,
// then written to the output queue, from which the master side shows it.
// Reset: the table is cleared by a sweep over all OLD_GLYPHS (4096) entries, one
// entry per cycle; s_tready stays low during the sweep. Record state resets
// at once and again after every last byte.
// Stall: when m_tready is low the queue fills, the read stage holds, and
// s_tready drops once a pending result no longer fits.
module composite_glyph_gid_remap
    import cggr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // map_old_gid[15:0], map_new_gid[31:16], data_byte[39:32]
    input  logic        s_tuser,   // opcode
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte
    output logic        m_tuser,   // is_pad
    output logic        m_tlast    // out_last
);

    logic [15:0] pos_reg,   pos_next;
    logic        comp_reg,  comp_next;
    logic [15:0] nro_reg,   nro_next;
    logic [15:0] flags_reg, flags_next;
    logic [7:0]  held_reg,  held_next;
    logic        done_reg,  done_next;

    logic        st1_valid_reg, st1_valid_next;
    logic        st1_id_reg,    st1_id_next;
    logic        st1_emit_reg,  st1_emit_next;
    logic        st1_pad_reg,   st1_pad_next;
    logic        st1_last_reg,  st1_last_next;
    logic        st1_range_reg, st1_range_next;
    logic [7:0]  st1_byte_reg,  st1_byte_next;

    logic [15:0] old_gid;
    logic [15:0] new_gid;
    logic [7:0]  byte_in;
    logic        s_accept;
    logic        byte_accept;
    logic        map_accept;
    logic        comp_now;
    logic [15:0] diff;
    logic        walking;
    logic [1:0]  rel;
    logic [15:0] comp_id;
    logic [16:0] nx;
    logic [15:0] pos_inc;

    map_req_t           ram_req;
    logic [15:0]        ram_rd_data;
    logic               ram_busy;
    logic [15:0]        mapped;
    logic [1:0]         st1_n;
    logic               advance;
    logic [1:0]         push_cnt;
    out_item_t          push0;
    out_item_t          push1;
    out_item_t          head;
    logic [FIFO_CW-1:0] fifo_count;
    logic               pop;

    assign old_gid = s_tdata[15:0];
    assign new_gid = s_tdata[31:16];
    assign byte_in = s_tdata[39:32];

    assign s_accept    = s_tvalid && s_tready;
    assign byte_accept = s_accept && (s_tuser == OP_BYTE);
    assign map_accept  = s_accept && (s_tuser == OP_MAP);

    // component walk decode
    always_comb
    begin
        comp_now = (pos_reg == 16'd0) ? byte_in[7] : comp_reg;
        diff     = 16'(pos_reg - nro_reg);
        walking  = comp_now && !done_reg && (pos_reg >= nro_reg) && (diff < 16'd4);
        rel      = diff[1:0];
        comp_id  = {held_reg, byte_in};
        nx       = {1'b0, pos_reg} + 17'd1
                 + (((flags_reg & FLAG_ARGS_WORDS) != 16'd0) ? 17'd4 : 17'd2);
        if ((flags_reg & FLAG_SCALE) != 16'd0)
        begin
            nx = 17'(nx + 17'd2);
        end
        else if ((flags_reg & FLAG_XY_SCALE) != 16'd0)
        begin
            nx = 17'(nx + 17'd4);
        end
        else if ((flags_reg & FLAG_TWO_BY_TWO) != 16'd0)
        begin
            nx = 17'(nx + 17'd8);
        end
        pos_inc = 16'(pos_reg + 1'b1);
    end

    // record state and read-stage load
    always_comb
    begin
        pos_next   = pos_reg;
        comp_next  = comp_reg;
        nro_next   = nro_reg;
        flags_next = flags_reg;
        held_next  = held_reg;
        done_next  = done_reg;

        st1_valid_next = st1_valid_reg;
        st1_id_next    = st1_id_reg;
        st1_emit_next  = st1_emit_reg;
        st1_pad_next   = st1_pad_reg;
        st1_last_next  = st1_last_reg;
        st1_range_next = st1_range_reg;
        st1_byte_next  = st1_byte_reg;

        ram_req.wr_en   = map_accept && ({1'b0, old_gid} < 17'(OLD_GLYPHS));
        ram_req.wr_addr = old_gid[GID_AW-1:0];
        ram_req.wr_data = new_gid;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = comp_id[GID_AW-1:0];

        if (advance)
        begin
            st1_valid_next = 1'b0;
        end

        if (byte_accept)
        begin
            st1_valid_next = 1'b1;
            st1_byte_next  = byte_in;
            st1_id_next    = walking && (rel == 2'd3);
            st1_emit_next  = !walking || (rel != 2'd3 && (rel != 2'd2 || s_tlast));
            st1_pad_next   = s_tlast && !pos_reg[0];
            st1_last_next  = s_tlast;
            st1_range_next = {1'b0, comp_id} < 17'(OLD_GLYPHS);

            if (pos_reg == 16'd0)
            begin
                comp_next = byte_in[7];
            end

            if (walking)
            begin
                case (rel)
                    2'd0:
                    begin
                        flags_next = {byte_in, 8'h00};
                    end
                    2'd1:
                    begin
                        flags_next = flags_reg | {8'h00, byte_in};
                    end
                    2'd2:
                    begin
                        held_next = byte_in;
                    end
                    2'd3:
                    begin
                        ram_req.rd_en = 1'b1;
                        if (((flags_reg & FLAG_MORE) == 16'd0) || nx[16])
                        begin
                            done_next = 1'b1;
                        end
                        else
                        begin
                            nro_next = nx[15:0];
                        end
                    end
                    default:
                    begin
                        flags_next = flags_reg;
                    end
                endcase
            end

            if (s_tlast)
            begin
                pos_next   = 16'd0;
                comp_next  = 1'b0;
                nro_next   = FIRST_COMPONENT;
                flags_next = 16'd0;
                held_next  = 8'd0;
                done_next  = 1'b0;
            end
            else
            begin
                pos_next = pos_inc;
                if (pos_inc == 16'd0)
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= 16'd0;
            comp_reg      <= 1'b0;
            nro_reg       <= FIRST_COMPONENT;
            flags_reg     <= 16'd0;
            held_reg      <= 8'd0;
            done_reg      <= 1'b0;
            st1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            comp_reg      <= comp_next;
            nro_reg       <= nro_next;
            flags_reg     <= flags_next;
            held_reg      <= held_next;
            done_reg      <= done_next;
            st1_valid_reg <= st1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st1_id_reg    <= st1_id_next;
        st1_emit_reg  <= st1_emit_next;
        st1_pad_reg   <= st1_pad_next;
        st1_last_reg  <= st1_last_next;
        st1_range_reg <= st1_range_next;
        st1_byte_reg  <= st1_byte_next;
    end

    cggr_gid_map u_map (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (ram_req),
        .rd_data (ram_rd_data),
        .busy    (ram_busy)
    );

    // read stage: build up to two results from the held item
    always_comb
    begin
        mapped = st1_range_reg ? ram_rd_data : 16'd0;
        if (st1_id_reg)
        begin
            st1_n = 2'd2;
        end
        else
        begin
            st1_n = 2'({1'b0, st1_emit_reg} + {1'b0, st1_pad_reg});
        end

        if (st1_id_reg)
        begin
            push0 = '{data: mapped[15:8], pad: 1'b0, last: 1'b0};
            push1 = '{data: mapped[7:0],  pad: 1'b0, last: st1_last_reg};
        end
        else if (st1_emit_reg)
        begin
            push0 = '{data: st1_byte_reg, pad: 1'b0, last: st1_last_reg && !st1_pad_reg};
            push1 = '{data: 8'd0,         pad: 1'b1, last: st1_last_reg};
        end
        else
        begin
            push0 = '{data: 8'd0, pad: 1'b1, last: st1_last_reg};
            push1 = '{data: 8'd0, pad: 1'b1, last: st1_last_reg};
        end

        advance  = st1_valid_reg &&
                   (({1'b0, fifo_count} + (FIFO_CW + 1)'(st1_n)) <= (FIFO_CW + 1)'(FIFO_DEPTH));
        push_cnt = advance ? st1_n : 2'd0;
    end

    assign s_tready = !ram_busy && (!st1_valid_reg || advance);

    cggr_out_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cnt (push_cnt),
        .push0    (push0),
        .push1    (push1),
        .pop      (pop),
        .head     (head),
        .count    (fifo_count)
    );

    assign m_tvalid = (fifo_count != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = head.data;
    assign m_tuser  = head.pad;
    assign m_tlast  = head.last;

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        ram_busy |-> !s_tready)
        else $error("input taken during table clear");

    a_map_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        map_accept |=> !st1_valid_reg)
        else $error("map transaction reached the read stage");

    a_lookup_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_accept && ram_req.rd_en) |=> (st1_valid_reg && st1_id_reg))
        else $error("table read without matching id item");

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count <= FIFO_CW'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_id_odd_position: assert property (@(posedge clk) disable iff (!rst_n)
        (st1_valid_reg && st1_id_reg) |-> !st1_pad_reg)
        else $error("pad requested after rewritten id");

endmodule

// File: rtl/cggr_gid_map.sv
module cggr_gid_map
    import cggr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  map_req_t    req,
    output logic [15:0] rd_data,
    output logic        busy
);

    logic [15:0]       map_mem [OLD_GLYPHS];
    logic [GID_AW-1:0] clr_addr_reg;
    logic [GID_AW-1:0] clr_addr_next;
    logic              busy_reg;
    logic              busy_next;
    logic [15:0]       rd_data_reg;

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        busy_next     = busy_reg;
        if (busy_reg)
        begin
            clr_addr_next = GID_AW'(clr_addr_reg + 1'b1);
            if (clr_addr_reg == GID_AW'(OLD_GLYPHS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            busy_reg     <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            busy_reg     <= busy_next;
        end
    end

    // sweep zeros through the table after reset, then take map writes
    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            map_mem[clr_addr_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            map_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= map_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule

// File: rtl/cggr_out_fifo.sv
module cggr_out_fifo
    import cggr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [1:0]         push_cnt,
    input  out_item_t          push0,
    input  out_item_t          push1,
    input  logic               pop,
    output out_item_t          head,
    output logic [FIFO_CW-1:0] count
);

    out_item_t          fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = FIFO_AW'(wr_ptr_reg + push_cnt);
        rd_ptr_next = FIFO_AW'(rd_ptr_reg + pop);
        count_next  = FIFO_CW'(count_reg + push_cnt - pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            fifo_mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            fifo_mem[FIFO_AW'(wr_ptr_reg + 1'b1)] <= push1;
        end
    end

    assign head  = fifo_mem[rd_ptr_reg];
    assign count = count_reg;

endmodule
